FILE: design/pvs_pkg.sv
package pvs_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_KP          = 3'd0;
  localparam logic [2:0] REG_KI          = 3'd1;
  localparam logic [2:0] REG_KD          = 3'd2;
  localparam logic [2:0] REG_MAX_ACCEL   = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED   = 3'd4;
  localparam logic [2:0] REG_USTEP_ANGLE = 3'd5;
  localparam logic [2:0] REG_EXT_MODE    = 3'd6;
  localparam logic [2:0] REG_EN_LOW      = 3'd7;

  // register reset values
  localparam logic [30:0] MAX_ACCEL_RST = 31'd131072;
  localparam logic [30:0] MAX_SPEED_RST = 31'd655360;
  localparam logic [31:0] USTEP_RST     = 32'd134929349;

  // dt clamp for the slew limit: 1 ms and 20 ms in Q0.24
  localparam logic [18:0] DT_MIN = 19'd16777;
  localparam logic [18:0] DT_MAX = 19'd335544;

  // derivative divider: 56-bit dividend, 24-bit divisor, 4 quotient bits a cycle
  localparam int DIV_DW   = 56;
  localparam int DIV_VW   = 24;
  localparam int DIV_BITS = 4;
  localparam int DIV_ITER = DIV_DW / DIV_BITS;
  localparam int DIV_CW   = $clog2(DIV_ITER + 1);

  // datapath operation codes
  localparam logic [4:0] OP_IDLE  = 5'd0;
  localparam logic [4:0] OP_LATCH = 5'd1;
  localparam logic [4:0] OP_SET   = 5'd2;
  localparam logic [4:0] OP_MSTEP = 5'd3;
  localparam logic [4:0] OP_TGT   = 5'd4;
  localparam logic [4:0] OP_DIS   = 5'd5;
  localparam logic [4:0] OP_ERR   = 5'd6;
  localparam logic [4:0] OP_MKI   = 5'd7;
  localparam logic [4:0] OP_IMAG  = 5'd8;
  localparam logic [4:0] OP_MHI   = 5'd9;
  localparam logic [4:0] OP_MLO   = 5'd10;
  localparam logic [4:0] OP_IACC  = 5'd11;
  localparam logic [4:0] OP_IADD  = 5'd12;
  localparam logic [4:0] OP_MKP   = 5'd13;
  localparam logic [4:0] OP_PSAVE = 5'd14;
  localparam logic [4:0] OP_DERIV = 5'd15;
  localparam logic [4:0] OP_MKD   = 5'd16;
  localparam logic [4:0] OP_DSUM  = 5'd17;
  localparam logic [4:0] OP_MDV   = 5'd18;
  localparam logic [4:0] OP_SLEW  = 5'd19;
  localparam logic [4:0] OP_CLAMP = 5'd20;
  localparam logic [4:0] OP_PUB   = 5'd21;

  typedef struct packed {
    logic [4:0] op;
    logic       div_start;
  } pvs_cmd_t;

  typedef struct packed {
    logic disabled;
    logic div_done;
  } pvs_sts_t;

endpackage

FILE: design/pvs_if.sv
interface pvs_req_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] new_target;
  logic signed [31:0] measured_angle;
  logic [23:0]        dt;
  logic [15:0]        pulse_count;
  logic               dir_level;
  logic               enable_level;

  modport source (output valid, operation, new_target, measured_angle, dt, pulse_count,
                  dir_level, enable_level, input ready);
  modport sink (input valid, operation, new_target, measured_angle, dt, pulse_count,
                dir_level, enable_level, output ready);
endinterface

interface pvs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] speed_command;
  logic               driver_enabled;
  logic               speed_rising;
  logic               speed_capped;
  logic signed [31:0] target_now;

  modport source (output valid, speed_command, driver_enabled, speed_rising, speed_capped,
                  target_now, input ready);
  modport sink (input valid, speed_command, driver_enabled, speed_rising, speed_capped,
                target_now, output ready);
endinterface

FILE: design/pvs_div.sv
module pvs_div import pvs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_DW-1:0] dividend_i,
  input  logic [DIV_VW-1:0] divisor_i,
  output logic [DIV_DW-1:0] quo_o,
  output logic              done_o
);

  logic [DIV_DW-1:0] dq_q, dq_d;
  logic [DIV_VW-1:0] rem_q, rem_d;
  logic [DIV_VW-1:0] dvs_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [DIV_VW:0] r;
    dq_d  = dq_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      r    = {rem_d, dq_d[DIV_DW-1]};
      dq_d = {dq_d[DIV_DW-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r        = r - {1'b0, dvs_q};
        dq_d[0]  = 1'b1;
      end
      rem_d = r[DIV_VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_ITER - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = dq_q;
  assign done_o = done_q;

endmodule

FILE: design/pvs_datapath.sv
module pvs_datapath import pvs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvs_cmd_t           cmd_i,
  output pvs_sts_t           sts_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] new_target_i,
  input  logic signed [31:0] measured_angle_i,
  input  logic [23:0]        dt_i,
  input  logic [15:0]        pulse_count_i,
  input  logic               dir_level_i,
  input  logic               enable_level_i,
  output logic signed [31:0] speed_command_o,
  output logic               driver_enabled_o,
  output logic               speed_rising_o,
  output logic               speed_capped_o,
  output logic signed [31:0] target_now_o
);

  localparam int RndSh  = 31 - FRAC_BITS;
  localparam int StepSh = 32 - FRAC_BITS;
  localparam int DtSh   = FRAC_BITS - 8;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    else if (v < -68'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // configuration
  logic signed [31:0] kp_q, ki_q, kd_q;
  logic [30:0]        max_accel_q, max_speed_q;
  logic [31:0]        ustep_q;
  logic               ext_q, eal_q;

  // latched request
  logic signed [31:0] new_tgt_q, meas_q;
  logic [23:0]        dt_q;
  logic [15:0]        pulses_q;
  logic               dir_q, en_q;

  // controller state
  logic signed [31:0] target_q, prev_q, speed_q;
  logic signed [47:0] integ_q;

  // work registers
  logic signed [65:0] prod_q;
  logic signed [31:0] err_q, deriv_q, u_q;
  logic [62:0]        mag_q;
  logic               neg_q, dneg_q;
  logic [55:0]        a_q;
  logic signed [56:0] inc_q;
  logic signed [65:0] psum_q;
  logic signed [33:0] nc_q;

  // pending and published result
  logic signed [31:0] pend_spd_q, pend_tgt_q;
  logic               pend_drv_q, pend_acc_q, pend_cap_q;
  logic signed [31:0] res_spd_q, res_tgt_q;
  logic               res_drv_q, res_acc_q, res_cap_q;

  // combinational terms
  logic signed [32:0] ma, mb;
  logic [48:0]        step_sum, step_v;
  logic signed [67:0] tgt_w;
  logic signed [31:0] tgt_new, err_w;
  logic signed [32:0] diff_w;
  logic [31:0]        dmag;
  logic [55:0]        isum, im;
  logic signed [57:0] iadd;
  logic signed [47:0] integ_new;
  logic [DIV_DW-1:0]  quo;
  logic               div_done;
  logic signed [31:0] deriv_w;
  logic signed [67:0] dsum;
  logic [18:0]        de;
  logic [33:0]        dv;
  logic signed [33:0] u34, c34, ud, nc_w;
  logic [33:0]        magu, magc, magd, magn;
  logic signed [33:0] lim;
  logic signed [31:0] clamped;
  logic               active;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      max_accel_q <= MAX_ACCEL_RST;
      max_speed_q <= MAX_SPEED_RST;
      ustep_q     <= USTEP_RST;
      ext_q       <= 1'b0;
      eal_q       <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:          kp_q        <= $signed(cfg_data_i);
        REG_KI:          ki_q        <= $signed(cfg_data_i);
        REG_KD:          kd_q        <= $signed(cfg_data_i);
        REG_MAX_ACCEL:   max_accel_q <= cfg_data_i[30:0];
        REG_MAX_SPEED:   max_speed_q <= cfg_data_i[30:0];
        REG_USTEP_ANGLE: ustep_q     <= cfg_data_i;
        REG_EXT_MODE:    ext_q       <= cfg_data_i[0];
        REG_EN_LOW:      eal_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MSTEP: begin
        ma = $signed({17'b0, pulses_q});
        mb = $signed({1'b0, ustep_q});
      end
      OP_MKI: begin
        ma = $signed({err_q[31], err_q});
        mb = $signed({ki_q[31], ki_q});
      end
      OP_MHI: begin
        ma = $signed({2'b0, mag_q[62:32]});
        mb = $signed({9'b0, dt_q});
      end
      OP_MLO: begin
        ma = $signed({1'b0, mag_q[31:0]});
        mb = $signed({9'b0, dt_q});
      end
      OP_MKP: begin
        ma = $signed({err_q[31], err_q});
        mb = $signed({kp_q[31], kp_q});
      end
      OP_MKD: begin
        ma = $signed({deriv_q[31], deriv_q});
        mb = $signed({kd_q[31], kd_q});
      end
      OP_MDV: begin
        ma = $signed({2'b0, max_accel_q});
        mb = $signed({14'b0, de});
      end
      default: ;
    endcase
  end

  // target stepping and enable gate
  always_comb begin
    step_sum = {1'b0, prod_q[47:0]} + (49'd1 << RndSh);
    step_v   = step_sum >> StepSh;
    if (dir_q) tgt_w = 68'(target_q) + $signed({19'b0, step_v});
    else       tgt_w = 68'(target_q) - $signed({19'b0, step_v});
    tgt_new = sat32(tgt_w);
    active  = eal_q ? !en_q : en_q;
  end

  // error and derivative dividend
  always_comb begin
    err_w  = sat32(68'(target_q) - 68'(meas_q));
    diff_w = 33'(err_w) - 33'(prev_q);
    dmag   = diff_w[32] ? 32'(-diff_w) : diff_w[31:0];
  end

  // integral increment and accumulation
  always_comb begin
    isum      = a_q + {32'b0, prod_q[55:32]};
    im        = isum >> DtSh;
    iadd      = 58'(integ_q) + 58'(inc_q);
    if (iadd > 58'sd140737488355327) integ_new = 48'sh7fffffffffff;
    else if (iadd < -58'sd140737488355328) integ_new = 48'sh800000000000;
    else integ_new = iadd[47:0];
  end

  // derivative from the quotient, saturated
  always_comb begin
    if (dt_q == '0) deriv_w = '0;
    else if (dneg_q) begin
      if (quo >= 56'h80000000) deriv_w = 32'sh80000000;
      else deriv_w = -$signed(quo[31:0]);
    end else begin
      if (quo >= 56'h80000000) deriv_w = 32'sh7fffffff;
      else deriv_w = $signed(quo[31:0]);
    end
  end

  // PID sum, slew and clamp terms
  always_comb begin
    dsum = 68'(psum_q) + 68'(integ_q) + 68'(prod_q >>> FRAC_BITS);
    if (dt_q < 24'(DT_MIN)) de = DT_MIN;
    else if (dt_q > 24'(DT_MAX)) de = DT_MAX;
    else de = dt_q[18:0];
    dv   = {8'b0, prod_q[49:24]};
    u34  = 34'(u_q);
    c34  = 34'(speed_q);
    ud   = u34 - c34;
    magu = u34[33] ? 34'(-u34) : 34'(u34);
    magc = c34[33] ? 34'(-c34) : 34'(c34);
    magd = ud[33] ? 34'(-ud) : 34'(ud);
    if (magu > magc && magd > dv) begin
      if (u34 > c34) nc_w = c34 + $signed(dv);
      else nc_w = c34 - $signed(dv);
    end else begin
      nc_w = u34;
    end
    magn = nc_q[33] ? 34'(-nc_q) : 34'(nc_q);
    lim  = $signed({3'b0, max_speed_q});
    if (nc_q > lim) clamped = lim[31:0];
    else if (nc_q < -lim) clamped = 32'(-lim);
    else clamped = nc_q[31:0];
  end

  pvs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({dmag, 24'b0}),
    .divisor_i  (dt_q),
    .quo_o      (quo),
    .done_o     (div_done)
  );

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      prev_q   <= '0;
      speed_q  <= '0;
      integ_q  <= '0;
    end else begin
      case (cmd_i.op)
        OP_SET:   target_q <= new_tgt_q;
        OP_TGT:   if (ext_q && pulses_q != '0) target_q <= tgt_new;
        OP_DIS:   speed_q <= '0;
        OP_ERR:   prev_q <= err_w;
        OP_IADD:  integ_q <= integ_new;
        OP_CLAMP: speed_q <= clamped;
        default: ;
      endcase
    end
  end

  // work and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        new_tgt_q <= new_target_i;
        meas_q    <= measured_angle_i;
        dt_q      <= dt_i;
        pulses_q  <= pulse_count_i;
        dir_q     <= dir_level_i;
        en_q      <= enable_level_i;
      end
      OP_SET: begin
        pend_spd_q <= speed_q;
        pend_drv_q <= 1'b0;
        pend_acc_q <= 1'b0;
        pend_cap_q <= 1'b0;
        pend_tgt_q <= new_tgt_q;
      end
      OP_DIS: begin
        pend_spd_q <= '0;
        pend_drv_q <= 1'b0;
        pend_acc_q <= 1'b0;
        pend_cap_q <= 1'b0;
        pend_tgt_q <= target_q;
      end
      OP_ERR: begin
        err_q  <= err_w;
        dneg_q <= diff_w[32];
      end
      OP_IMAG: begin
        mag_q <= prod_q[65] ? 63'(-prod_q) : prod_q[62:0];
        neg_q <= prod_q[65];
      end
      OP_MLO:   a_q <= prod_q[55:0];
      OP_IACC:  inc_q <= neg_q ? -$signed({1'b0, im}) : $signed({1'b0, im});
      OP_PSAVE: psum_q <= prod_q >>> FRAC_BITS;
      OP_DERIV: deriv_q <= deriv_w;
      OP_DSUM:  u_q <= sat32(dsum);
      OP_SLEW:  nc_q <= nc_w;
      OP_CLAMP: begin
        pend_spd_q <= clamped;
        pend_drv_q <= 1'b1;
        pend_acc_q <= magn > magc;
        pend_cap_q <= 34'(clamped) != nc_q;
        pend_tgt_q <= target_q;
      end
      OP_PUB: begin
        res_spd_q <= pend_spd_q;
        res_drv_q <= pend_drv_q;
        res_acc_q <= pend_acc_q;
        res_cap_q <= pend_cap_q;
        res_tgt_q <= pend_tgt_q;
      end
      default: ;
    endcase
    // shared multiplier, registered
    if (cmd_i.op == OP_MSTEP || cmd_i.op == OP_MKI || cmd_i.op == OP_MHI ||
        cmd_i.op == OP_MLO || cmd_i.op == OP_MKP || cmd_i.op == OP_MKD ||
        cmd_i.op == OP_MDV) begin
      prod_q <= ma * mb;
    end
  end

  assign sts_o.disabled = ext_q && !active;
  assign sts_o.div_done = div_done;

  assign speed_command_o  = res_spd_q;
  assign driver_enabled_o = res_drv_q;
  assign speed_rising_o   = res_acc_q;
  assign speed_capped_o   = res_cap_q;
  assign target_now_o     = res_tgt_q;

endmodule

FILE: design/pvs_ctrl.sv
module pvs_ctrl import pvs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pvs_sts_t sts_i,
  output pvs_cmd_t cmd_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SET   = 5'd1;
  localparam logic [4:0] ST_MSTEP = 5'd2;
  localparam logic [4:0] ST_TGT   = 5'd3;
  localparam logic [4:0] ST_DIS   = 5'd4;
  localparam logic [4:0] ST_ERR   = 5'd5;
  localparam logic [4:0] ST_MKI   = 5'd6;
  localparam logic [4:0] ST_IMAG  = 5'd7;
  localparam logic [4:0] ST_MHI   = 5'd8;
  localparam logic [4:0] ST_MLO   = 5'd9;
  localparam logic [4:0] ST_IACC  = 5'd10;
  localparam logic [4:0] ST_IADD  = 5'd11;
  localparam logic [4:0] ST_MKP   = 5'd12;
  localparam logic [4:0] ST_PSAVE = 5'd13;
  localparam logic [4:0] ST_DWAIT = 5'd14;
  localparam logic [4:0] ST_DERIV = 5'd15;
  localparam logic [4:0] ST_MKD   = 5'd16;
  localparam logic [4:0] ST_DSUM  = 5'd17;
  localparam logic [4:0] ST_MDV   = 5'd18;
  localparam logic [4:0] ST_SLEW  = 5'd19;
  localparam logic [4:0] ST_CLAMP = 5'd20;
  localparam logic [4:0] ST_PUB   = 5'd21;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.op        = OP_IDLE;
    cmd_o.div_start = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = in_op_i ? ST_SET : ST_MSTEP;
        end
      end
      ST_SET: begin
        cmd_o.op = OP_SET;
        state_d  = ST_PUB;
      end
      ST_MSTEP: begin
        cmd_o.op = OP_MSTEP;
        state_d  = ST_TGT;
      end
      ST_TGT: begin
        cmd_o.op = OP_TGT;
        state_d  = sts_i.disabled ? ST_DIS : ST_ERR;
      end
      ST_DIS: begin
        cmd_o.op = OP_DIS;
        state_d  = ST_PUB;
      end
      ST_ERR: begin
        cmd_o.op        = OP_ERR;
        cmd_o.div_start = 1'b1;
        state_d         = ST_MKI;
      end
      ST_MKI: begin
        cmd_o.op = OP_MKI;
        state_d  = ST_IMAG;
      end
      ST_IMAG: begin
        cmd_o.op = OP_IMAG;
        state_d  = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.op = OP_MHI;
        state_d  = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.op = OP_MLO;
        state_d  = ST_IACC;
      end
      ST_IACC: begin
        cmd_o.op = OP_IACC;
        state_d  = ST_IADD;
      end
      ST_IADD: begin
        cmd_o.op = OP_IADD;
        state_d  = ST_MKP;
      end
      ST_MKP: begin
        cmd_o.op = OP_MKP;
        state_d  = ST_PSAVE;
      end
      ST_PSAVE: begin
        cmd_o.op = OP_PSAVE;
        state_d  = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts_i.div_done) state_d = ST_DERIV;
      end
      ST_DERIV: begin
        cmd_o.op = OP_DERIV;
        state_d  = ST_MKD;
      end
      ST_MKD: begin
        cmd_o.op = OP_MKD;
        state_d  = ST_DSUM;
      end
      ST_DSUM: begin
        cmd_o.op = OP_DSUM;
        state_d  = ST_MDV;
      end
      ST_MDV: begin
        cmd_o.op = OP_MDV;
        state_d  = ST_SLEW;
      end
      ST_SLEW: begin
        cmd_o.op = OP_SLEW;
        state_d  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        state_d  = ST_PUB;
      end
      ST_PUB: begin
        // wait for the output register to free up
        if (slot_free) begin
          cmd_o.op    = OP_PUB;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/pid_velocity_slew_controller_top.sv
// A set-target request, a disabled tick and a full control tick take different paths
// through the sequencer; a full tick waits on the derivative divider (4 quotient
// bits a cycle), which runs beside the steps on the shared multiplier.
// A new request is taken only when the sequencer is idle; the result register lets
// the next request enter while a result waits. Reset (rst_ni, async, low)
// clears the PID state, the target and speed, and loads register defaults.
module pid_velocity_slew_controller_top import pvs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pvs_req_if.sink     req_i,
  pvs_rsp_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  pvs_cmd_t cmd;
  pvs_sts_t sts;

  pvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pvs_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .new_target_i     (req_i.new_target),
    .measured_angle_i (req_i.measured_angle),
    .dt_i             (req_i.dt),
    .pulse_count_i    (req_i.pulse_count),
    .dir_level_i      (req_i.dir_level),
    .enable_level_i   (req_i.enable_level),
    .speed_command_o  (rsp_o.speed_command),
    .driver_enabled_o (rsp_o.driver_enabled),
    .speed_rising_o   (rsp_o.speed_rising),
    .speed_capped_o   (rsp_o.speed_capped),
    .target_now_o     (rsp_o.target_now)
  );

endmodule

FILE: tb/tb_pvs_if_drv.sv
// Handshake monitor on the request and result channels: flags any cycle in
// which a request or a result is accepted.
module tb_pvs_chan_tie (
  pvs_req_if.source req,
  pvs_rsp_if.sink   rsp,
  output logic      accept_o
);
  timeunit 1ns;
  timeprecision 1ps;

  assign accept_o = (req.valid && req.ready) || (rsp.valid && rsp.ready);
endmodule

FILE: tb/tb_pid_velocity_slew_controller_top.sv
module tb_pid_velocity_slew_controller_top;
  import pvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int WATCHDOG = 20000;
  localparam int N_RAND = 1700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = REG_KP;
  logic [31:0] cfg_data_i = '0;
  logic any_accept;

  pvs_req_if req_if ();
  pvs_rsp_if rsp_if ();

  pid_velocity_slew_controller_top #(.FRAC_BITS(FB)) u_dut (
    .clk_i, .rst_ni, .req_i(req_if.sink), .rsp_o(rsp_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  tb_pvs_chan_tie u_tie (.req(req_if.source), .rsp(rsp_if.sink), .accept_o(any_accept));

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  typedef struct {
    logic        operation;
    logic [31:0] new_target;
    logic [31:0] measured_angle;
    logic [23:0] dt;
    logic [15:0] pulse_count;
    logic        dir_level;
    logic        enable_level;
  } request_t;

  typedef struct {
    logic [31:0] speed_command;
    logic        driver_enabled;
    logic        speed_rising;
    logic        speed_capped;
    logic [31:0] target_now;
  } speed_out_t;

  // predictor copy of registers and state
  logic signed [31:0] m_kp, m_ki, m_kd;
  logic [30:0] m_max_accel, m_max_speed;
  logic [31:0] m_ustep;
  logic m_ext, m_en_low;
  longint m_target, m_prev_err, m_speed, m_integ;

  speed_out_t expected_speeds[$];
  int errors = 0;
  int idle_pct = 26;
  int quiet_cycles = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic model_reset();
    m_kp = 0; m_ki = 0; m_kd = 0;
    m_max_accel = MAX_ACCEL_RST; m_max_speed = MAX_SPEED_RST;
    m_ustep = USTEP_RST; m_ext = 0; m_en_low = 1;
    m_target = 0; m_prev_err = 0; m_speed = 0; m_integ = 0;
  endtask

  // the control law: set target, target stepping, enable gate, PID, slew limit and clamp
  function automatic speed_out_t predict_speed(request_t r);
    speed_out_t o;
    longint err, prod, inc, s, diff, deriv, p, d, u, dv, nc, lim, clamped, cmd;
    logic [63:0] mm, hi, lo, im, q, stp;
    longint de;
    logic active;
    if (r.operation) begin
      m_target = longint'($signed(r.new_target));
      o = '{m_speed[31:0], 1'b0, 1'b0, 1'b0, m_target[31:0]};
      return o;
    end
    if (m_ext) begin
      if (r.pulse_count != 0) begin
        mm = 64'(r.pulse_count) * 64'(m_ustep);
        stp = (mm + (64'd1 << (31 - FB))) >> (32 - FB);
        m_target = clip32(r.dir_level ? m_target + longint'(stp) : m_target - longint'(stp));
      end
      active = m_en_low ? (r.enable_level == 1'b0) : (r.enable_level == 1'b1);
      if (!active) begin
        m_speed = 0;
        o = '{32'd0, 1'b0, 1'b0, 1'b0, m_target[31:0]};
        return o;
      end
    end
    err = clip32(m_target - longint'($signed(r.measured_angle)));
    // integral
    prod = err * longint'(m_ki);
    mm = 64'(mag64(prod));
    hi = (mm >> 32) * 64'(r.dt);
    lo = (mm & 64'hFFFF_FFFF) * 64'(r.dt);
    im = (hi + (lo >> 32)) >> (FB - 8);
    inc = prod < 0 ? -longint'(im) : longint'(im);
    s = m_integ + inc;
    if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
    m_integ = s;
    // derivative
    if (r.dt == 0) deriv = 0;
    else begin
      diff = err - m_prev_err;
      q = (64'(mag64(diff)) << 24) / 64'(r.dt);
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      deriv = clip32(diff < 0 ? -longint'(q) : longint'(q));
    end
    m_prev_err = err;
    p = (err * longint'(m_kp)) >>> FB;
    d = (deriv * longint'(m_kd)) >>> FB;
    u = clip32(p + m_integ + d);
    // slew limit on rises in magnitude
    de = r.dt < DT_MIN ? DT_MIN : (r.dt > DT_MAX ? DT_MAX : r.dt);
    dv = longint'((64'(m_max_accel) * 64'(de)) >> 24);
    cmd = m_speed;
    if (mag64(u) > mag64(cmd) && mag64(u - cmd) > dv) nc = u > cmd ? cmd + dv : cmd - dv;
    else nc = u;
    lim = longint'(m_max_speed);
    clamped = nc > lim ? lim : (nc < -lim ? -lim : nc);
    m_speed = clamped;
    o = '{m_speed[31:0], 1'b1, mag64(nc) > mag64(cmd), clamped != nc, m_target[31:0]};
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.operation = 1'b0;
    req_if.new_target = '0;
    req_if.measured_angle = '0;
    req_if.dt = '0;
    req_if.pulse_count = '0;
    req_if.dir_level = 1'b0;
    req_if.enable_level = 1'b0;
    rsp_if.ready = 1'b0;
  end

  // result sink: random stall, compare on accept
  always @(posedge clk_i) begin
    speed_out_t w;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_speeds.size() == 0) begin
          report_mismatch("unexpected result", rsp_if.speed_command, 32'd0);
        end else begin
          w = expected_speeds.pop_front();
          if (rsp_if.speed_command !== w.speed_command)
            report_mismatch("speed_command", rsp_if.speed_command, w.speed_command);
          if (rsp_if.driver_enabled !== w.driver_enabled)
            report_mismatch("driver_enabled", 32'(rsp_if.driver_enabled), 32'(w.driver_enabled));
          if (rsp_if.speed_rising !== w.speed_rising)
            report_mismatch("speed_rising", 32'(rsp_if.speed_rising), 32'(w.speed_rising));
          if (rsp_if.speed_capped !== w.speed_capped)
            report_mismatch("speed_capped", 32'(rsp_if.speed_capped), 32'(w.speed_capped));
          if (rsp_if.target_now !== w.target_now)
            report_mismatch("target_now", rsp_if.target_now, w.target_now);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if (any_accept) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_KP: m_kp = val;
      REG_KI: m_ki = val;
      REG_KD: m_kd = val;
      REG_MAX_ACCEL: m_max_accel = val[30:0];
      REG_MAX_SPEED: m_max_speed = val[30:0];
      REG_USTEP_ANGLE: m_ustep = val;
      REG_EXT_MODE: m_ext = val[0];
      default: m_en_low = val[0];
    endcase
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // present one request, with random idle cycles ahead of it
  task automatic send_request(request_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= r.operation;
    req_if.new_target <= r.new_target;
    req_if.measured_angle <= r.measured_angle;
    req_if.dt <= r.dt;
    req_if.pulse_count <= r.pulse_count;
    req_if.dir_level <= r.dir_level;
    req_if.enable_level <= r.enable_level;
    do @(posedge clk_i); while (!req_if.ready);
    expected_speeds.push_back(predict_speed(r));
  endtask

  // directed table entry: request plus optional fixed expectation
  typedef struct {
    request_t   r;
    logic       fixed;
    speed_out_t want;
  } directed_row_t;

  function automatic request_t make_req(logic op, logic [31:0] tg, logic [31:0] ma,
                                        logic [23:0] dt, logic [15:0] pc, logic dir,
                                        logic en);
    request_t r;
    r = '{op, tg, ma, dt, pc, dir, en};
    return r;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int sel;
    sel = $urandom_range(9);
    r.operation = ($urandom_range(9) == 0);
    r.new_target = (sel == 0) ? $urandom() : 32'($signed($urandom_range(400000)) - 200000);
    r.measured_angle = (sel == 1) ? $urandom() : 32'($signed($urandom_range(400000)) - 200000);
    case ($urandom_range(5))
      0: r.dt = 24'd0;
      1: r.dt = 24'($urandom());
      2: r.dt = 24'hFFFFFF;
      default: r.dt = 24'($urandom_range(400000));
    endcase
    r.pulse_count = (sel == 2) ? 16'($urandom()) : 16'($urandom_range(20));
    r.dir_level = 1'($urandom_range(1));
    r.enable_level = ($urandom_range(7) == 0) ? !m_en_low : m_en_low ? 1'b0 : 1'b1;
    if ($urandom_range(15) == 0) r.enable_level = 1'($urandom_range(1));
    return r;
  endfunction

  directed_row_t dir_rows[$];

  initial begin
    directed_row_t row;
    int phase;
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: reset readback, extremes, zero dt
    row.fixed = 1; row.r = make_req(1, 32'h7FFF_FFFF, 0, 0, 0, 1, 0);
    row.want = '{32'd0, 0, 0, 0, 32'h7FFF_FFFF}; dir_rows.push_back(row);
    row.r = make_req(1, 32'h8000_0000, 0, 0, 0, 1, 0);
    row.want = '{32'd0, 0, 0, 0, 32'h8000_0000}; dir_rows.push_back(row);
    row.fixed = 0;
    row.r = make_req(0, 0, 32'h7FFF_FFFF, 24'd0, 0, 1, 0); dir_rows.push_back(row);
    row.r = make_req(0, 0, 32'h8000_0000, 24'hFFFFFF, 16'hFFFF, 0, 1); dir_rows.push_back(row);
    row.r = make_req(1, 32'd65536, 0, 0, 0, 1, 0); dir_rows.push_back(row);
    row.r = make_req(0, 0, 32'd0, 24'd100, 0, 1, 0); dir_rows.push_back(row);
    row.r = make_req(0, 0, 32'hFFFF_0000, 24'd400000, 0, 1, 0); dir_rows.push_back(row);
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].r);
      if (dir_rows[i].fixed) begin
        expected_speeds.pop_back();
        expected_speeds.push_back(dir_rows[i].want);
      end
    end
    wait_drained();

    // gains at extremes, external mode with both enable polarities
    write_reg(REG_KP, 32'h7FFF_FFFF); write_reg(REG_KI, 32'h8000_0000);
    write_reg(REG_KD, 32'h7FFF_FFFF); write_reg(REG_MAX_ACCEL, 32'h7FFF_FFFF);
    write_reg(REG_MAX_SPEED, 32'h7FFF_FFFF); write_reg(REG_USTEP_ANGLE, 32'hFFFF_FFFF);
    write_reg(REG_EXT_MODE, 32'd1); write_reg(REG_EN_LOW, 32'd1);
    send_request(make_req(0, 0, 0, 24'd16777, 16'hFFFF, 1, 1));
    send_request(make_req(0, 0, 0, 24'd16777, 16'hFFFF, 1, 0));
    send_request(make_req(0, 0, 32'h8000_0000, 24'd1, 16'hFFFF, 0, 0));
    wait_drained();
    write_reg(REG_EN_LOW, 32'd0);
    send_request(make_req(0, 0, 0, 24'd335545, 16'd1, 0, 1));
    send_request(make_req(0, 0, 0, 24'd0, 16'd3, 1, 0));
    wait_drained();

    // random phases over several register settings
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_KP, 32'h0001_0000); write_reg(REG_KI, 32'h0000_8000);
          write_reg(REG_KD, 32'h0000_0100); write_reg(REG_MAX_ACCEL, 32'(MAX_ACCEL_RST));
          write_reg(REG_MAX_SPEED, 32'(MAX_SPEED_RST)); write_reg(REG_EXT_MODE, 32'd0);
        end
        1: begin
          write_reg(REG_EXT_MODE, 32'd1); write_reg(REG_EN_LOW, 32'd1);
          write_reg(REG_USTEP_ANGLE, USTEP_RST); write_reg(REG_MAX_ACCEL, 32'd0);
          write_reg(REG_MAX_SPEED, 32'd0);
        end
        2: begin
          write_reg(REG_KP, $urandom()); write_reg(REG_KI, $urandom());
          write_reg(REG_KD, $urandom()); write_reg(REG_MAX_ACCEL, $urandom());
          write_reg(REG_MAX_SPEED, $urandom()); write_reg(REG_USTEP_ANGLE, $urandom());
        end
        3: begin
          write_reg(REG_KP, 32'hFFFE_0000); write_reg(REG_KI, 32'h7FFF_FFFF);
          write_reg(REG_KD, 32'h8000_0000); write_reg(REG_EN_LOW, 32'd0);
          write_reg(REG_MAX_SPEED, 32'd3000000); write_reg(REG_MAX_ACCEL, 32'd5000000);
        end
        4: begin
          idle_pct = 0;
          write_reg(REG_EXT_MODE, 32'd0); write_reg(REG_KP, 32'h0004_0000);
          write_reg(REG_KI, 32'd0); write_reg(REG_KD, 32'd0);
        end
        default: begin
          idle_pct = 26;
          write_reg(REG_KP, $urandom()); write_reg(REG_KI, $urandom_range(200000));
          write_reg(REG_EXT_MODE, 32'd1);
        end
      endcase
      repeat (N_RAND / 6) send_request(random_req());
      wait_drained();
    end

    wait_drained();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
